[rtl/core/cct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg
// shared types and constants for the compare/capture timer
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int CountWidth = 32;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 32;

    // action codes
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_START       = 3'd1;
    localparam logic [2:0] ACT_STOP        = 3'd2;
    localparam logic [2:0] ACT_CLEAR       = 3'd3;
    localparam logic [2:0] ACT_SHUTDOWN    = 3'd4;
    localparam logic [2:0] ACT_CAPTURE     = 3'd5;
    localparam logic [2:0] ACT_CLEAR_EVENT = 3'd6;
    localparam logic [2:0] ACT_WRITE_CAP   = 3'd7;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_BIT_WIDTH_MODE     = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_COMPARE_VALUE      = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SHORTS_MODE        = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_COMPARE_IRQ_ENABLE = 2'd3;

    // bit width modes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_24 = 2'd2;
    localparam logic [1:0] WIDTH_32 = 2'd3;

    // shorts modes
    localparam logic [1:0] SHORT_NONE  = 2'd0;
    localparam logic [1:0] SHORT_CLEAR = 2'd1;
    localparam logic [1:0] SHORT_STOP  = 2'd2;

    localparam logic [CountWidth-1:0] MASK_8BIT  = 32'h0000_00ff;
    localparam logic [CountWidth-1:0] MASK_16BIT = 32'h0000_ffff;
    localparam logic [CountWidth-1:0] MASK_24BIT = 32'h00ff_ffff;
    localparam logic [CountWidth-1:0] MASK_32BIT = 32'hffff_ffff;

    typedef struct packed {
        logic [2:0]            action;
        logic [CountWidth-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [CountWidth-1:0] capture_value;
        logic                  compare_event;
        logic                  running;
        logic                  irq_request;
    } out_item_t;

    function automatic logic [CountWidth-1:0] width_mask(input logic [1:0] mode);
        logic [CountWidth-1:0] m;
        case (mode)
            WIDTH_8:  m = MASK_8BIT;
            WIDTH_16: m = MASK_16BIT;
            WIDTH_24: m = MASK_24BIT;
            default:  m = MASK_32BIT;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/compare_capture_timer.sv]
// each accepted transaction's result is registered, in the skid entry while a result waits
// throughput: one transaction per cycle while in_stall is low, set by the single state update
// a two-entry result buffer keeps input flowing while a result waits
// reset: counter, capture and event cleared, timer stopped and shut down,
// configuration registers zero
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compare_capture_timer
// timer with width select, compare event, shorts and capture register
// ----------------------------------------------------------------------------
module compare_capture_timer
    import cct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data
);

    logic [1:0]            bit_width_mode_reg;
    logic [CountWidth-1:0] compare_value_reg;
    logic [1:0]            shorts_mode_reg;
    logic                  compare_irq_enable_reg;

    logic [CountWidth-1:0] count_reg, count_next;
    logic [CountWidth-1:0] captured_reg, captured_next;
    logic                  running_reg, running_next;
    logic                  shut_down_reg, shut_down_next;
    logic                  event_reg, event_next;

    out_item_t             out_reg, skid_reg;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  accept;
    logic                  out_take;
    logic [CountWidth-1:0] tick_count;
    out_item_t             result;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign tick_count = (count_reg + 32'd1) & width_mask(bit_width_mode_reg);

    always_comb
    begin
        count_next     = count_reg;
        captured_next  = captured_reg;
        running_next   = running_reg;
        shut_down_next = shut_down_reg;
        event_next     = event_reg;
        case (in_data.action)
            ACT_TICK:
            begin
                if (running_reg && !shut_down_reg)
                begin
                    count_next = tick_count;
                    if (tick_count == compare_value_reg)
                    begin
                        event_next = 1'b1;
                        if (shorts_mode_reg == SHORT_CLEAR)
                            count_next = '0;
                        else if (shorts_mode_reg == SHORT_STOP)
                            running_next = 1'b0;
                    end
                end
            end
            ACT_START:
            begin
                running_next   = 1'b1;
                shut_down_next = 1'b0;
            end
            ACT_STOP:        running_next = 1'b0;
            ACT_CLEAR:       count_next = '0;
            ACT_SHUTDOWN:
            begin
                running_next   = 1'b0;
                shut_down_next = 1'b1;
                count_next     = '0;
            end
            ACT_CAPTURE:     captured_next = shut_down_reg ? '0 : count_reg;
            ACT_CLEAR_EVENT: event_next = 1'b0;
            ACT_WRITE_CAP:   captured_next = in_data.write_value;
            default:         captured_next = captured_reg;
        endcase
        result.capture_value = captured_next;
        result.compare_event = event_next;
        result.running       = running_next;
        result.irq_request   = event_next && compare_irq_enable_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_width_mode_reg     <= WIDTH_8;
            compare_value_reg      <= '0;
            shorts_mode_reg        <= SHORT_NONE;
            compare_irq_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BIT_WIDTH_MODE:     bit_width_mode_reg <= cfg_data[1:0];
                REG_COMPARE_VALUE:      compare_value_reg <= cfg_data[CountWidth-1:0];
                REG_SHORTS_MODE:        shorts_mode_reg <= cfg_data[1:0];
                REG_COMPARE_IRQ_ENABLE: compare_irq_enable_reg <= cfg_data[0];
                default:                shorts_mode_reg <= shorts_mode_reg;
            endcase
        end
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            captured_reg  <= '0;
            running_reg   <= 1'b0;
            shut_down_reg <= 1'b1;
            event_reg     <= 1'b0;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            captured_reg  <= captured_next;
            running_reg   <= running_next;
            shut_down_reg <= shut_down_next;
            event_reg     <= event_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    // skid entry only holds data behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    // counter stays zero while shut down
    assert property (@(posedge clk) disable iff (!rst_n)
        shut_down_reg |-> (count_reg == '0) && !running_reg)
        else $error("counter active while shut down");

    // interrupt request only with a set event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.irq_request) |-> out_reg.compare_event)
        else $error("interrupt request without compare event");

    // a waiting result is kept until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule
